@@ hdl/lrukv_pkg.sv @@
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared types and constants for the LRU key/value cache: channel items,
// controller states, and the command/status groups that link the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lrukv_pkg;

    localparam int FIELD_BITS         = 32;
    localparam int DEF_NUM_ENTRIES    = 16;
    localparam int DEF_KEY_BITS       = 32;
    localparam int DEF_VALUE_BITS     = 32;

    typedef struct packed {
        logic [FIELD_BITS-1:0] lookup_key;
        logic [FIELD_BITS-1:0] fill_value;
    } t_req;

    typedef struct packed {
        logic                  hit;
        logic [FIELD_BITS-1:0] value_out;
        logic                  evicted;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic rsp_busy;
    } t_status;

endpackage

@@ hdl/lrukv_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrukv_ctrl
// Sequencer for the cache: takes an item, runs the tag compare cycle, then
// the update cycle that commits state and loads the result register.
// ----------------------------------------------------------------------------
module lrukv_ctrl
    import lrukv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_req_stall
);

    t_state r_state;
    t_state n_state;
    logic   ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        ready         = 1'b0;
        o_cmd.lookup  = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                ready = 1'b1;
                if (i_req_valid) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_UPD;
            end
            ST_UPD: begin
                if (!i_status.rsp_busy) begin
                    o_cmd.commit = 1'b1;
                    ready        = 1'b1;
                    n_state      = i_req_valid ? ST_CMP : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_cmd.capture = i_req_valid && ready;
    end

    assign o_req_stall = !ready;

endmodule

@@ hdl/lrukv_dp.sv @@
// ----------------------------------------------------------------------------
// lrukv_dp
// Cache datapath: key registers with parallel compare, value memory, valid
// bits, recency ranks, occupancy count and the result register.
// ----------------------------------------------------------------------------
module lrukv_dp
    import lrukv_pkg::*;
#(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_req    i_req,
    input  t_cmd    i_cmd,
    input  logic    i_rsp_stall,
    output t_status o_status,
    output logic    o_rsp_valid,
    output t_rsp    o_rsp
);

    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int OCC_W = $clog2(NUM_ENTRIES + 1);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_fill;
    logic [KEY_BITS-1:0]   r_keys   [NUM_ENTRIES];
    logic [VALUE_BITS-1:0] r_values [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_vld;
    logic [IDX_W-1:0]      r_rank   [NUM_ENTRIES];
    logic [OCC_W-1:0]      r_occ;
    logic [VALUE_BITS-1:0] r_rdata;
    logic                  r_hit;
    logic                  r_evict;
    logic [IDX_W-1:0]      r_slot;
    logic [IDX_W-1:0]      r_hit_rank;
    logic                  r_rsp_valid;
    t_rsp                  r_rsp;

    logic [NUM_ENTRIES-1:0] match;
    logic [IDX_W-1:0]       match_idx;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       victim_idx;
    logic [IDX_W-1:0]       slot;
    logic                   hit;
    logic                   full;

    // parallel tag compare and slot selection
    always_comb begin
        match_idx  = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            match[i] = r_vld[i] && (r_keys[i] == r_key);
            if (match[i]) begin
                match_idx = IDX_W'(i);
            end
            if (!r_vld[i]) begin
                free_idx = IDX_W'(i);
            end
            // when full the ranks form a permutation, oldest holds the top rank
            if (r_rank[i] == IDX_W'(NUM_ENTRIES - 1)) begin
                victim_idx = IDX_W'(i);
            end
        end
        hit  = |match;
        full = (r_occ == OCC_W'(NUM_ENTRIES));
        if (hit) begin
            slot = match_idx;
        end else if (!full) begin
            slot = free_idx;
        end else begin
            slot = victim_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key  <= KEY_BITS'(i_req.lookup_key);
            r_fill <= VALUE_BITS'(i_req.fill_value);
        end
        if (i_cmd.lookup) begin
            r_hit      <= hit;
            r_evict    <= !hit && full;
            r_slot     <= slot;
            r_hit_rank <= r_rank[match_idx];
        end
    end

    // value memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_rdata <= r_values[slot];
        end
        if (i_cmd.commit && !r_hit) begin
            r_values[r_slot] <= r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_hit) begin
            r_keys[r_slot] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_occ <= '0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (r_slot == IDX_W'(i)) begin
                    r_rank[i] <= '0;
                end else if (r_vld[i] && (!r_hit || (r_rank[i] < r_hit_rank))) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
            if (!r_hit) begin
                r_vld[r_slot] <= 1'b1;
                if (!r_evict) begin
                    r_occ <= r_occ + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp.hit       <= r_hit;
            r_rsp.value_out <= r_hit ? FIELD_BITS'(r_rdata) : FIELD_BITS'(r_fill);
            r_rsp.evicted   <= r_evict;
        end
    end

    assign o_status.rsp_busy = r_rsp_valid && i_rsp_stall;
    assign o_rsp_valid       = r_rsp_valid;
    assign o_rsp             = r_rsp;

endmodule

@@ hdl/lru_key_value_cache_unit.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative LRU key/value cache, top level.
// ----------------------------------------------------------------------------
// Each request item gives a key and a fill value and yields one result item:
// a hit returns the stored value and makes the entry most recent; a miss
// stores the key with the fill value as most recent, evicting the least
// recent entry when all entries are in use. An item passes the compare state,
// for the parallel key compare against every entry, then the update state,
// for the rank update and state commit; the next item is accepted in the
// update state while the result register is free. The result register holds
// while the output is stalled; a new item is still taken and waits in its
// update cycle until the register frees.
module lru_key_value_cache_unit
    import lrukv_pkg::*;
#(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    t_cmd    cmd;
    t_status status;

    lrukv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_req_stall (o_req_stall)
    );

    lrukv_dp #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .i_rsp_stall (i_rsp_stall),
        .o_status    (status),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTH
    a_capture_then_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && cmd.capture) |=> cmd.lookup)
        else $error("captured item not followed by compare cycle");

    a_single_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.lookup |=> !cmd.lookup)
        else $error("compare cycle repeated");

    a_commit_loads_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && cmd.commit) |=> o_rsp_valid)
        else $error("commit did not present a result");
`endif

endmodule

@@ sim/lru_key_value_cache_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// Watches both channels of the LRU key/value cache. It keeps its own copy of
// the entries, valid marks and recency ranks. When a request item is taken it
// predicts the result item. Every result item is compared field by field with
// the oldest prediction, and each mismatch is counted for the testbench top.
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker
    import lrukv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_stall,
    input  t_rsp i_rsp,
    output int   o_error_count,
    output int   o_pending
);

    localparam int RANK_BITS    = $clog2(DEF_NUM_ENTRIES);
    localparam int REPORT_LIMIT = 100;

    logic [DEF_KEY_BITS-1:0]   slot_key   [DEF_NUM_ENTRIES];
    logic [DEF_VALUE_BITS-1:0] slot_value [DEF_NUM_ENTRIES];
    logic                      slot_live  [DEF_NUM_ENTRIES];
    logic [RANK_BITS-1:0]      slot_rank  [DEF_NUM_ENTRIES];
    int                        live_count   = 0;
    int                        error_total  = 0;
    int                        result_index = 0;
    t_rsp                      results_due[$];

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_total < REPORT_LIMIT) begin
            $display("%0t ns: result item %0d: %s got %h, want %h",
                     $time, result_index, field, got, want);
        end
        error_total++;
    endtask

    // make a slot most recent, aging every live slot ranked below limit
    function automatic void touch_slot(input int slot, input int limit);
        for (int i = 0; i < DEF_NUM_ENTRIES; i++) begin
            if (i != slot && slot_live[i] && slot_rank[i] < limit) begin
                slot_rank[i] = slot_rank[i] + 1'b1;
            end
        end
        slot_rank[slot] = '0;
    endfunction

    function automatic t_rsp predict_lookup(input t_req item);
        logic [DEF_KEY_BITS-1:0]   key;
        logic [DEF_VALUE_BITS-1:0] fill;
        logic [DEF_VALUE_BITS-1:0] value;
        int                        slot;
        int                        oldest;
        t_rsp                      result;
        key    = item.lookup_key;
        fill   = item.fill_value;
        slot   = -1;
        result = '0;
        for (int i = 0; i < DEF_NUM_ENTRIES; i++) begin
            if (slot < 0 && slot_live[i] && slot_key[i] == key) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            result.hit = 1'b1;
            value      = slot_value[slot];
            touch_slot(slot, slot_rank[slot]);
        end else begin
            if (live_count < DEF_NUM_ENTRIES) begin
                for (int i = 0; i < DEF_NUM_ENTRIES; i++) begin
                    if (slot < 0 && !slot_live[i]) begin
                        slot = i;
                    end
                end
                live_count++;
            end else begin
                // full: replace the largest rank, lowest index on a tie
                oldest = 0;
                slot   = 0;
                for (int i = 0; i < DEF_NUM_ENTRIES; i++) begin
                    if (slot_live[i] && slot_rank[i] > oldest) begin
                        oldest = slot_rank[i];
                        slot   = i;
                    end
                end
                result.evicted = 1'b1;
            end
            slot_key[slot]   = key;
            slot_value[slot] = fill;
            slot_live[slot]  = 1'b1;
            value            = fill;
            touch_slot(slot, DEF_NUM_ENTRIES);
        end
        result.value_out = value;
        return result;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEF_NUM_ENTRIES; i++) begin
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_live[i]  = 1'b0;
                slot_rank[i]  = '0;
            end
            live_count = 0;
            results_due.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected item, value_out", i_rsp.value_out, '0);
                end else begin
                    want = results_due.pop_front();
                    if (i_rsp.hit !== want.hit) begin
                        report_mismatch("hit", i_rsp.hit, want.hit);
                    end
                    if (i_rsp.value_out !== want.value_out) begin
                        report_mismatch("value_out", i_rsp.value_out, want.value_out);
                    end
                    if (i_rsp.evicted !== want.evicted) begin
                        report_mismatch("evicted", i_rsp.evicted, want.evicted);
                    end
                end
                result_index++;
            end
            if (i_req_valid && !i_req_stall) begin
                results_due.push_back(predict_lookup(i_req));
            end
        end
        o_pending     <= results_due.size();
        o_error_count <= error_total;
    end

endmodule

@@ sim/tb_lru_key_value_cache_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit
// Drives lookup items into the LRU key/value cache: a directed run through
// key extremes, hits, fills up to full and evictions, then random segments
// over key pools smaller and larger than the cache. Both sides idle at
// random. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;
    import lrukv_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int MAX_WAIT       = 15;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } t_idle_mode;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    t_req       req       = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    t_rsp       rsp;
    int         error_count;
    int         pending;
    int         quiet_cycles = 0;
    t_idle_mode send_mode    = IDLE_NONE;
    t_idle_mode drain_mode   = IDLE_NONE;

    always #(CLK_PERIOD / 2) clk = ~clk;

    lru_key_value_cache_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_stall(req_stall),
        .i_req      (req),
        .o_rsp_valid(rsp_valid),
        .i_rsp_stall(rsp_stall),
        .o_rsp      (rsp)
    );

    lru_key_value_cache_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_rsp        (rsp),
        .o_error_count(error_count),
        .o_pending    (pending)
    );

    function automatic int draw_wait(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(MAX_WAIT, 0);
            default:   return ($urandom_range(3, 0) == 0) ? $urandom_range(MAX_WAIT, 0) : 0;
        endcase
    endfunction

    task automatic send_lookup(input logic [31:0] key, input logic [31:0] fill);
        int gap;
        gap = draw_wait(send_mode);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= {key, fill};
        do @(posedge clk); while (req_stall);
    endtask

    initial begin : stimulus
        logic [31:0] key;
        logic [31:0] key_pool[$];
        int          pool_size;
        int          seg_len;
        int          sent;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_mode  = IDLE_SPARSE;
        drain_mode = IDLE_SPARSE;

        // key extremes, then hits that ignore the fill value
        send_lookup(32'h0000_0000, 32'h0000_0000);
        send_lookup(32'hffff_ffff, 32'hffff_ffff);
        send_lookup(32'h0000_0000, 32'h1234_5678);
        send_lookup(32'hffff_ffff, 32'h0000_0000);
        // fill every entry
        for (int k = 1; k <= 14; k++) begin
            send_lookup(k, k * 32'h0101_0101);
        end
        // hit on the oldest entry, then evictions and hits when full
        send_lookup(32'h0000_0000, 32'hdead_beef);
        send_lookup(32'h0000_0100, 32'h8000_0001);
        send_lookup(32'h0000_0001, 32'h7fff_fffe);
        send_lookup(32'hffff_ffff, 32'h5555_5555);
        send_lookup(32'h0000_0003, 32'haaaa_aaaa);
        send_lookup(32'ha5a5_a5a5, 32'h5a5a_5a5a);
        // hit on the most recent entry
        send_lookup(32'ha5a5_a5a5, 32'h0f0f_0f0f);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            send_mode  = t_idle_mode'($urandom_range(2, 0));
            drain_mode = t_idle_mode'($urandom_range(2, 0));
            case ($urandom_range(6, 0))
                0:       pool_size = 2;
                1:       pool_size = 8;
                2:       pool_size = 15;
                3:       pool_size = 16;
                4:       pool_size = 17;
                5:       pool_size = 24;
                default: pool_size = 48;
            endcase
            key_pool.delete();
            for (int i = 0; i < pool_size; i++) begin
                key_pool.push_back($urandom());
            end
            seg_len = $urandom_range(150, 50);
            for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++) begin
                if ($urandom_range(9, 0) == 0) begin
                    key = $urandom();
                end else begin
                    key = key_pool[$urandom_range(pool_size - 1, 0)];
                end
                send_lookup(key, $urandom());
                sent++;
            end
        end
        req_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : result_drain
        int hold;
        do @(posedge clk); while (!rst_n);
        forever begin
            hold = draw_wait(drain_mode);
            if (hold > 0) begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ sim.f @@
hdl/lrukv_pkg.sv
hdl/lrukv_ctrl.sv
hdl/lrukv_dp.sv
hdl/lru_key_value_cache_unit.sv
sim/lru_key_value_cache_checker.sv
sim/tb_lru_key_value_cache_unit.sv
